FILE: src/sesub_pkg.sv
// Shared types and constants for the segment equal subdivider.
`default_nettype none
package sesub_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_QUOT,
    ST_STEP,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input item
    logic sq_start;  // form squared length
    logic sqrt_init;
    logic sqrt_iter;
    logic quot_init;
    logic quot_iter;
    logic step_init;
    logic step_iter;
    logic emit_load; // load first point into the output register
    logic emit_adv;  // advance to next point
    logic out_clear;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sqrt_done;
    logic quot_done;
    logic step_done;
    logic out_busy;
    logic last_loaded;
  } stat_t;

  localparam int SqrtBits  = 34;
  localparam int LenW      = 34;
  localparam int DeltaW    = 33;

endpackage
`default_nettype wire

FILE: src/sesub_ctrl.sv
// Controller state machine for the segment equal subdivider.
`default_nettype none
module sesub_ctrl
  import sesub_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_start  = 1'b1;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.quot_init = 1'b1;
          state_next    = ST_QUOT;
        end else begin
          cmd.sqrt_iter = 1'b1;
        end
      end
      ST_QUOT: begin
        if (stat.quot_done) begin
          cmd.step_init = 1'b1;
          state_next    = ST_STEP;
        end else begin
          cmd.quot_iter = 1'b1;
        end
      end
      ST_STEP: begin
        if (stat.step_done) begin
          if (!stat.out_busy) begin
            cmd.emit_load = 1'b1;
            state_next    = ST_EMIT;
          end
        end else begin
          cmd.step_iter = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          if (stat.last_loaded) state_next = ST_IDLE;
          else cmd.emit_adv = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/sesub_dp.sv
// Datapath: squared length, root, quotient, step division and point output.
`default_nettype none
module sesub_dp
  import sesub_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  wire signed [31:0]  start_x,
  input  wire signed [31:0]  start_y,
  input  wire signed [31:0]  end_x,
  input  wire signed [31:0]  end_y,
  input  wire                two_regions,
  input  wire [30:0]         size_first,
  input  wire [30:0]         size_second,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [5:0]         point_index,
  output logic [6:0]         point_count,
  output logic               capped,
  output logic               last_point
);

  localparam int CntW = $clog2(MAX_POINTS + 1);

  // Captured item
  logic signed [31:0]      sx, sy;
  logic signed [DeltaW-1:0] dx, dy;
  logic [30:0]             size;
  logic [65:0]             sq;       // dx^2 + dy^2
  logic [SqrtBits-1:0]     root;
  logic [5:0]              bitn;     // iteration counter
  logic [LenW-1:0]         rem;
  logic [LenW-1:0]         qt;
  logic [CntW-1:0]         count;
  logic                    cap;
  logic [DeltaW-1:0]       ax, ay;   // magnitude dividends, become quotients
  logic [DeltaW-1:0]       rx, ry;
  logic signed [DeltaW:0]  stepx, stepy;
  logic signed [31:0]      curx, cury;
  logic [5:0]              idx;
  logic                    busy;

  wire [30:0] size_pick = (two_regions && size_second < size_first) ? size_second : size_first;
  wire signed [32:0] dxw = $signed({end_x[31], end_x}) - $signed({start_x[31], start_x});
  wire signed [32:0] dyw = $signed({end_y[31], end_y}) - $signed({start_y[31], start_y});

  // Squares of magnitudes, one multiplier each
  wire [DeltaW-1:0] mx = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
  wire [DeltaW-1:0] my = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);
  logic [65:0] sqx, sqy;

  // Root trial: candidate squared compared with target
  wire [SqrtBits-1:0] trial = root | (SqrtBits'(1) << bitn);
  logic [67:0] trial_sq;
  assign trial_sq = trial * trial;

  wire [LenW:0]  qsub = {rem[LenW-2:0], root[bitn]} - {4'd0, size};
  logic [CntW-1:0] div;
  wire [DeltaW:0] xsub = {rx, ax[DeltaW-1]} - {{(DeltaW+1-CntW){1'b0}}, div};
  wire [DeltaW:0] ysub = {ry, ay[DeltaW-1]} - {{(DeltaW+1-CntW){1'b0}}, div};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= start_x; sy <= start_y; dx <= dxw; dy <= dyw;
      size <= (size_pick == '0) ? 31'd1 : size_pick;
    end
    if (cmd.sq_start) begin
      sqx  <= 66'(mx) * 66'(mx);
      sqy  <= 66'(my) * 66'(my);
      root <= '0;
      bitn <= 6'(SqrtBits - 1);
    end
    if (cmd.sqrt_iter) begin
      if (bitn == 6'(SqrtBits - 1)) sq <= sqx + sqy;
      if (bitn != 6'(SqrtBits - 1) || 1'b1) begin
        if (trial_sq <= {2'b0, (bitn == 6'(SqrtBits - 1)) ? sqx + sqy : sq}) root <= trial;
      end
      bitn <= bitn - 6'd1;
    end
    if (cmd.quot_init) begin
      rem  <= '0;
      qt   <= '0;
      bitn <= 6'(LenW - 1);
    end
    if (cmd.quot_iter) begin
      if (!qsub[LenW]) begin
        rem <= qsub[LenW-1:0];
        qt  <= {qt[LenW-2:0], 1'b1};
      end else begin
        rem <= {rem[LenW-2:0], root[bitn]};
        qt  <= {qt[LenW-2:0], 1'b0};
      end
      bitn <= bitn - 6'd1;
    end
    if (cmd.step_init) begin
      if (qt >= LenW'(MAX_POINTS)) begin
        count <= CntW'(MAX_POINTS); cap <= 1'b1;
        div   <= CntW'(MAX_POINTS - 1);
      end else begin
        count <= CntW'(qt) + CntW'(1); cap <= 1'b0;
        div   <= (qt == '0) ? CntW'(1) : CntW'(qt);
      end
      ax <= mx; ay <= my; rx <= '0; ry <= '0;
      bitn <= 6'(DeltaW - 1);
    end
    if (cmd.step_iter) begin
      rx <= xsub[DeltaW] ? {rx[DeltaW-2:0], ax[DeltaW-1]} : xsub[DeltaW-1:0];
      ry <= ysub[DeltaW] ? {ry[DeltaW-2:0], ay[DeltaW-1]} : ysub[DeltaW-1:0];
      ax <= {ax[DeltaW-2:0], ~xsub[DeltaW]};
      ay <= {ay[DeltaW-2:0], ~ysub[DeltaW]};
      bitn <= bitn - 6'd1;
    end
  end

  // Signed steps, zero for a single node
  wire [CntW-1:0] one_c = CntW'(1);
  always_comb begin
    stepx = (count == one_c) ? '0 : (dx[DeltaW-1] ? -$signed({1'b0, ax}) : $signed({1'b0, ax}));
    stepy = (count == one_c) ? '0 : (dy[DeltaW-1] ? -$signed({1'b0, ay}) : $signed({1'b0, ay}));
  end

  // Output register
  wire last_next = (7'(idx) + 7'd1 == 7'(count));
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.emit_load || cmd.emit_adv) out_valid <= 1'b1;
    end
    if (cmd.emit_load) begin
      curx <= sx; cury <= sy; idx <= '0;
      point_x <= sx; point_y <= sy; point_index <= '0;
      point_count <= 7'(count); capped <= cap;
      last_point <= (count == one_c);
    end
    if (cmd.emit_adv) begin
      curx <= 32'(curx + stepx); cury <= 32'(cury + stepy);
      point_x <= 32'(curx + stepx); point_y <= 32'(cury + stepy);
      idx <= idx + 6'd1; point_index <= idx + 6'd1;
      last_point <= (7'(idx) + 7'd2 == 7'(count));
    end
  end

  assign busy = out_valid && out_stall;
  assign stat.sqrt_done   = (bitn == 6'h3F);
  assign stat.quot_done   = (bitn == 6'h3F);
  assign stat.step_done   = (bitn == 6'h3F);
  assign stat.out_busy    = busy;
  assign stat.last_loaded = last_point && !last_next ? 1'b1 : last_point;

endmodule
`default_nettype wire

FILE: src/segment_equal_subdivider.sv
// Top level of the segment equal subdivider.
// An accepted item goes through a squaring step, then bit-serial loops over the 34 root
// bits, 34 quotient bits and 33 step-division bits, each loop ending in a hand-off.
// A new segment is taken only after the last point of the previous one has gone out;
// points go out one per cycle while out_stall is low.
// Reset clears the controller and the output valid; payload registers are not reset.
`default_nettype none
module segment_equal_subdivider
  import sesub_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  start_x,
  input  wire signed [31:0]  start_y,
  input  wire signed [31:0]  end_x,
  input  wire signed [31:0]  end_y,
  input  wire                two_regions,
  input  wire [30:0]         size_first,
  input  wire [30:0]         size_second,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [5:0]         point_index,
  output logic [6:0]         point_count,
  output logic               capped,
  output logic               last_point
);

  cmd_t  cmd;
  stat_t stat;

  sesub_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  sesub_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .two_regions(two_regions), .size_first(size_first), .size_second(size_second),
    .out_valid(out_valid), .out_stall(out_stall),
    .point_x(point_x), .point_y(point_y), .point_index(point_index),
    .point_count(point_count), .capped(capped), .last_point(last_point)
  );

endmodule
`default_nettype wire

FILE: src/sesub_check.sv
// Port-level checker for the segment equal subdivider, bound to the top level.
`default_nettype none
module sesub_check (
  input wire       clk,
  input wire       rst,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [5:0] point_index,
  input wire [6:0] point_count,
  input wire       last_point
);

  // Last flag matches index and count
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_point == (7'(point_index) + 7'd1 == point_count))) else $error("last");

  // Index never reaches count
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (7'(point_index) < point_count)) else $error("index");

  // No new item taken while points are still going out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_point) |-> in_stall) else $error("accept");

  // Held output keeps its index
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(point_index)) else $error("hold");

endmodule

bind segment_equal_subdivider sesub_check u_check (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .point_index(point_index), .point_count(point_count),
  .last_point(last_point)
);
`default_nettype wire
